// ----- rtl/fvpi_pkg.sv -----
package fvpi_pkg;

	localparam int FRAC_BITS = 8;
	localparam int GAIN_FRAC = 8;
	localparam int COUNT_W   = 16;
	localparam int GAIN_W    = 16;
	localparam int LIMIT_W   = 16;
	localparam int DRIVE_W   = 16;
	localparam int SUM_W     = COUNT_W + 1;
	// filtered speed and integral stay within +/- 2^(SUM_W-1) * 2^FRAC_BITS
	localparam int SPEED_W   = SUM_W + FRAC_BITS + 1;
	// 4*filtered + sum*2^F stays below 5 * 2^(SPEED_W-2)
	localparam int DIV_W     = SPEED_W + 2;
	localparam int DIV_CNT_W = $clog2(DIV_W);
	localparam int RAW_W     = SPEED_W + 1;
	localparam int ACC_W     = SPEED_W + GAIN_W + 1;
	localparam int MAC_CNT_W = $clog2(GAIN_W);
	localparam int VAL_W     = ACC_W - FRAC_BITS - GAIN_FRAC;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIM  = 2'd2;

	localparam logic [GAIN_W-1:0]  SPEED_GAIN_RST    = 16'd15360;
	localparam logic [GAIN_W-1:0]  INTEGRAL_GAIN_RST = 16'd102;
	localparam logic [LIMIT_W-1:0] INTEGRAL_LIM_RST  = 16'd2000;

	typedef struct packed {
		logic signed [COUNT_W-1:0] left_count;
		logic signed [COUNT_W-1:0] right_count;
	} in_item_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic                      drive_saturated;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_INTEG,
		ST_CLAMP,
		ST_MAC,
		ST_OUT
	} state_t;

endpackage

// ----- rtl/fvpi_div5.sv -----
module fvpi_div5 import fvpi_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [DIV_W-1:0] dividend,
	output logic                    done,
	output logic signed [DIV_W-1:0] quotient
);

	localparam logic [3:0] DIVISOR = 4'd5;

	logic                 busy_q;
	logic                 done_q;
	logic                 neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [2:0]           rem_q;
	logic [DIV_W-1:0]     shreg_q;
	logic [3:0]           trial;
	logic                 ge;
	logic [3:0]           diff;

	// restoring division, one quotient bit a cycle; dividend bits leave at the
	// top while quotient bits enter at the bottom of the same register
	assign trial = {rem_q, shreg_q[DIV_W-1]};
	assign ge    = (trial >= DIVISOR);
	assign diff  = trial - DIVISOR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q   <= dividend[DIV_W-1];
			shreg_q <= dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
			rem_q   <= '0;
		end else if (busy_q) begin
			shreg_q <= {shreg_q[DIV_W-2:0], ge};
			rem_q   <= ge ? diff[2:0] : trial[2:0];
		end
	end

	// truncation toward zero: divide the magnitude, then restore the sign
	assign quotient = neg_q ? -$signed(shreg_q) : $signed(shreg_q);
	assign done     = done_q;

endmodule

// ----- rtl/fvpi_mac.sv -----
module fvpi_mac import fvpi_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [SPEED_W-1:0] filt,
	input  logic signed [SPEED_W-1:0] integ,
	input  logic [GAIN_W-1:0]         kp,
	input  logic [GAIN_W-1:0]         ki,
	output logic                      done,
	output logic signed [ACC_W-1:0]   acc
);

	logic                    busy_q;
	logic                    done_q;
	logic                    phase_q;
	logic [MAC_CNT_W-1:0]    cnt_q;
	logic [GAIN_W-1:0]       gain_q;
	logic signed [ACC_W-1:0] opnd_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    last;

	assign last = (cnt_q == MAC_CNT_W'(GAIN_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					if (!phase_q) begin
						phase_q <= 1'b1;
					end else begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	// shift-add, gain bits LSB first: first pass filt*kp, second pass integ*ki
	always_ff @(posedge clk) begin
		if (start) begin
			opnd_q <= ACC_W'(filt);
			gain_q <= kp;
			acc_q  <= '0;
		end else if (busy_q) begin
			if (gain_q[0]) begin
				acc_q <= acc_q + opnd_q;
			end
			if (last && !phase_q) begin
				opnd_q <= ACC_W'(integ);
				gain_q <= ki;
			end else begin
				opnd_q <= opnd_q <<< 1;
				gain_q <= gain_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule

// ----- rtl/filtered_velocity_pi_loop_unit.sv -----
// Velocity PI loop on low-pass filtered wheel speed.
//
// Input channel (in_valid, in_stall, in_data): one request per control tick,
// holding the left and right encoder counts. Output channel (out_valid,
// out_stall, out_data): one result per request, the drive value and a flag
// set when it was clipped to the signed 16-bit range.
// Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0 speed
// gain, 1 integral gain, 2 integral limit; index 3 is ignored. cfg_ready is
// always high. Write only while no request is in flight.
//
// A request passes the serial divide by five (one quotient bit at a time),
// the integral update and clamp, the serial multiply (one gain bit at a
// time) and the output step. One request is worked at a time, so a new one
// is taken only after the last has left the output step.
// The result sits in an output register: a request may be accepted while the
// previous result still waits under out_stall; a finished result waits in the
// last step until that register frees.
// Reset clears filter and integral state and loads the default gains and integral limit.
module filtered_velocity_pi_loop_unit import fvpi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data
);

	state_t state_q;
	state_t state_nx;

	logic [GAIN_W-1:0]  kp_q;
	logic [GAIN_W-1:0]  ki_q;
	logic [LIMIT_W-1:0] lim_q;

	logic signed [SPEED_W-1:0] filt_q;
	logic signed [SPEED_W-1:0] integ_q;
	logic signed [RAW_W-1:0]   raw_q;
	out_item_t                 out_q;
	logic                      out_valid_q;

	logic                    accept;
	logic                    div_start;
	logic                    div_done;
	logic                    mac_start;
	logic                    mac_done;
	logic                    out_load;
	logic signed [SUM_W-1:0] sum;
	logic signed [DIV_W-1:0] dividend;
	logic signed [DIV_W-1:0] quotient;
	logic signed [ACC_W-1:0] acc;
	logic signed [RAW_W-1:0] lim_fix;
	logic signed [VAL_W-1:0] val;
	logic                    val_ovf;
	out_item_t               result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q  <= SPEED_GAIN_RST;
			ki_q  <= INTEGRAL_GAIN_RST;
			lim_q <= INTEGRAL_LIM_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SPEED_GAIN:    kp_q  <= cfg_data;
				CFG_INTEGRAL_GAIN: ki_q  <= cfg_data;
				CFG_INTEGRAL_LIM:  lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_nx = ST_DIV;
			ST_DIV:   if (div_done) state_nx = ST_INTEG;
			ST_INTEG: state_nx = ST_CLAMP;
			ST_CLAMP: state_nx = ST_MAC;
			ST_MAC:   if (mac_done) state_nx = ST_OUT;
			ST_OUT:   if (!out_valid_q || !out_stall) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall  = 1'b1;
		mac_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE:  in_stall  = 1'b0;
			ST_CLAMP: mac_start = 1'b1;
			ST_OUT:   out_load  = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	assign accept    = in_valid && !in_stall;
	assign div_start = accept;

	// filter numerator: 4*filtered + sum*2^F
	assign sum      = SUM_W'(in_data.left_count) + SUM_W'(in_data.right_count);
	assign dividend = (DIV_W'(filt_q) <<< 2) + (DIV_W'(sum) <<< FRAC_BITS);

	assign lim_fix = $signed({{(RAW_W - LIMIT_W - FRAC_BITS){1'b0}}, lim_q,
		{FRAC_BITS{1'b0}}});

	// drop the fraction toward zero: bump floor by one for inexact negatives
	assign val = VAL_W'(acc >>> (FRAC_BITS + GAIN_FRAC))
		+ VAL_W'(acc[ACC_W-1] && (acc[FRAC_BITS+GAIN_FRAC-1:0] != '0));
	assign val_ovf = (val[VAL_W-1:DRIVE_W-1] != '0) && (val[VAL_W-1:DRIVE_W-1] != '1);

	always_comb begin
		result.drive_saturated = val_ovf;
		if (val_ovf) begin
			result.drive = val[VAL_W-1] ? $signed({1'b1, {(DRIVE_W-1){1'b0}}})
				: $signed({1'b0, {(DRIVE_W-1){1'b1}}});
		end else begin
			result.drive = val[DRIVE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			filt_q      <= '0;
			integ_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_DIV && div_done) begin
				filt_q <= quotient[SPEED_W-1:0];
			end
			if (state_q == ST_CLAMP) begin
				if (raw_q > lim_fix) begin
					integ_q <= lim_fix[SPEED_W-1:0];
				end else if (raw_q < -lim_fix) begin
					integ_q <= SPEED_W'(-lim_fix);
				end else begin
					integ_q <= raw_q[SPEED_W-1:0];
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_INTEG) begin
			raw_q <= RAW_W'(integ_q) + RAW_W'(filt_q);
		end
		if (out_load) begin
			out_q <= result;
		end
	end

	fvpi_div5 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.done     (div_done),
		.quotient (quotient)
	);

	fvpi_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.filt   (filt_q),
		.integ  (integ_q),
		.kp     (kp_q),
		.ki     (ki_q),
		.done   (mac_done),
		.acc    (acc)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide step");

	a_mac_done_in_mac: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == ST_MAC)
		else $error("multiplier finished outside the multiply step");

	a_integ_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MAC |-> (RAW_W'(integ_q) <= lim_fix) && (RAW_W'(integ_q) >= -lim_fix))
		else $error("integral outside its limit during multiply");

	a_load_frees: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && state_q == ST_IDLE)
		else $error("result load did not present the result");

endmodule
